FILE: rtl/ble_pkg.sv
// ----------------------------------------------------------------------------
// ble_pkg: shared types and constants of the bounded list engine
// element store size, command and status codes, and the inter-module structs
// ----------------------------------------------------------------------------
package ble_pkg;

  localparam int CAPACITY = 256;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = ADDR_W + 1;
  localparam int DATA_W   = 32;

  localparam logic [DATA_W-1:0] ERR_VALUE = '1;

  typedef enum logic [2:0] {
    CMD_APPEND  = 3'd0,
    CMD_POP     = 3'd1,
    CMD_REMOVE  = 3'd2,
    CMD_INSERT  = 3'd3,
    CMD_SEARCH  = 3'd4,
    CMD_CLEAR   = 3'd5,
    CMD_REVERSE = 3'd6,
    CMD_LENGTH  = 3'd7
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_EMPTY  = 3'd1,
    ST_FULL   = 3'd2,
    ST_BADIDX = 3'd3,
    ST_ODD    = 3'd4
  } status_e;

  typedef struct packed {
    cmd_e              cmd;
    logic [DATA_W-1:0] value;
    logic [7:0]        position;
  } in_t;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              found;
    logic [CNT_W-1:0]  length;
    status_e           status;
  } res_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

endpackage

FILE: rtl/ble_mem.sv
// ----------------------------------------------------------------------------
// ble_mem: element store
// one write port and one read port with registered read data
// ----------------------------------------------------------------------------
module ble_mem (
  input  logic                        clk_i,
  input  ble_pkg::mem_req_t           req_i,
  output logic [ble_pkg::DATA_W-1:0]  rdata_o
);

  logic [ble_pkg::DATA_W-1:0] mem_q [ble_pkg::CAPACITY];
  logic [ble_pkg::DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/ble_ctrl.sv
// ----------------------------------------------------------------------------
// ble_ctrl: command sequencer
// walks the element store one entry per step with a shared index and compare
// ----------------------------------------------------------------------------
module ble_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  ble_pkg::in_t                in_i,
  output logic                        res_valid_o,
  input  logic                        res_take_i,
  output ble_pkg::res_t               res_o,
  output ble_pkg::mem_req_t           mem_req_o,
  input  logic [ble_pkg::DATA_W-1:0]  mem_rdata_i
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_READ  = 6'b000010,
    S_USE   = 6'b000100,
    S_WRJ   = 6'b001000,
    S_WRVAL = 6'b010000,
    S_DONE  = 6'b100000
  } state_e;

  localparam logic [ble_pkg::CNT_W-1:0] CapCnt = ble_pkg::CNT_W'(ble_pkg::CAPACITY);

  state_e                        state_q, state_d;
  ble_pkg::cmd_e                 cmd_q, cmd_d;
  logic [ble_pkg::DATA_W-1:0]    val_q, val_d;
  logic [ble_pkg::DATA_W-1:0]    tmp_q, tmp_d;
  logic [ble_pkg::CNT_W-1:0]     idx_q, idx_d;
  logic [ble_pkg::CNT_W-1:0]     jdx_q, jdx_d;
  logic [ble_pkg::CNT_W-1:0]     count_q, count_d;
  logic [ble_pkg::ADDR_W-1:0]    addr_q, addr_d;
  logic                          ph_q, ph_d;
  logic [ble_pkg::DATA_W-1:0]    res_val_q, res_val_d;
  logic                          res_hit_q, res_hit_d;
  ble_pkg::status_e              res_st_q, res_st_d;

  logic [ble_pkg::CNT_W-1:0]     idx_p1, idx_p2, idx_m1, idx_m2, jdx_m1, cnt_m1, half;
  logic [ble_pkg::CNT_W-1:0]     pos_ext;
  logic                          hit;

  assign idx_p1  = idx_q + ble_pkg::CNT_W'(1);
  assign idx_p2  = idx_q + ble_pkg::CNT_W'(2);
  assign idx_m1  = idx_q - ble_pkg::CNT_W'(1);
  assign idx_m2  = idx_q - ble_pkg::CNT_W'(2);
  assign jdx_m1  = jdx_q - ble_pkg::CNT_W'(1);
  assign cnt_m1  = count_q - ble_pkg::CNT_W'(1);
  assign half    = count_q >> 1;
  assign pos_ext = ble_pkg::CNT_W'(in_i.position);
  // the one shared comparator
  assign hit     = (mem_rdata_i == val_q);

  always_comb begin
    state_d   = state_q;
    cmd_d     = cmd_q;
    val_d     = val_q;
    tmp_d     = tmp_q;
    idx_d     = idx_q;
    jdx_d     = jdx_q;
    count_d   = count_q;
    addr_d    = addr_q;
    ph_d      = ph_q;
    res_val_d = res_val_q;
    res_hit_d = res_hit_q;
    res_st_d  = res_st_q;
    mem_req_o = '0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d     = in_i.cmd;
          val_d     = in_i.value;
          ph_d      = 1'b0;
          res_val_d = '0;
          res_hit_d = 1'b0;
          res_st_d  = ble_pkg::ST_OK;
          state_d   = S_DONE;
          case (in_i.cmd)
            ble_pkg::CMD_APPEND: begin
              if (count_q >= CapCnt) begin
                res_val_d = ble_pkg::ERR_VALUE;
                res_st_d  = ble_pkg::ST_FULL;
              end else begin
                mem_req_o.we    = 1'b1;
                mem_req_o.waddr = count_q[ble_pkg::ADDR_W-1:0];
                mem_req_o.wdata = in_i.value;
                count_d         = count_q + ble_pkg::CNT_W'(1);
              end
            end
            ble_pkg::CMD_POP: begin
              if (count_q == '0) begin
                res_val_d = ble_pkg::ERR_VALUE;
                res_st_d  = ble_pkg::ST_EMPTY;
              end else begin
                addr_d  = cnt_m1[ble_pkg::ADDR_W-1:0];
                state_d = S_READ;
              end
            end
            ble_pkg::CMD_REMOVE: begin
              if (pos_ext >= count_q) begin
                res_val_d = ble_pkg::ERR_VALUE;
                res_st_d  = ble_pkg::ST_BADIDX;
              end else begin
                idx_d   = pos_ext;
                addr_d  = pos_ext[ble_pkg::ADDR_W-1:0];
                state_d = S_READ;
              end
            end
            ble_pkg::CMD_INSERT: begin
              if (count_q[0]) begin
                res_val_d = ble_pkg::ERR_VALUE;
                res_st_d  = ble_pkg::ST_ODD;
              end else if (count_q >= CapCnt) begin
                res_val_d = ble_pkg::ERR_VALUE;
                res_st_d  = ble_pkg::ST_FULL;
              end else begin
                idx_d = count_q;
                // empty list: value goes straight to entry zero
                if (count_q != '0) begin
                  addr_d  = cnt_m1[ble_pkg::ADDR_W-1:0];
                  state_d = S_READ;
                end else begin
                  state_d = S_WRVAL;
                end
              end
            end
            ble_pkg::CMD_SEARCH: begin
              idx_d  = '0;
              addr_d = '0;
              if (count_q != '0) begin
                state_d = S_READ;
              end
            end
            ble_pkg::CMD_CLEAR: begin
              count_d = '0;
            end
            ble_pkg::CMD_REVERSE: begin
              idx_d  = '0;
              jdx_d  = cnt_m1;
              addr_d = '0;
              if (count_q >= ble_pkg::CNT_W'(2)) begin
                state_d = S_READ;
              end
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end

      S_READ: begin
        mem_req_o.re    = 1'b1;
        mem_req_o.raddr = addr_q;
        state_d         = S_USE;
      end

      S_USE: begin
        state_d = S_DONE;
        case (cmd_q)
          ble_pkg::CMD_POP: begin
            res_val_d = mem_rdata_i;
            count_d   = cnt_m1;
          end
          ble_pkg::CMD_REMOVE: begin
            if (!ph_q) begin
              res_val_d = mem_rdata_i;
              ph_d      = 1'b1;
              if (idx_p1 < count_q) begin
                addr_d  = idx_p1[ble_pkg::ADDR_W-1:0];
                state_d = S_READ;
              end else begin
                count_d = cnt_m1;
              end
            end else begin
              // move the next entry up by one
              mem_req_o.we    = 1'b1;
              mem_req_o.waddr = idx_q[ble_pkg::ADDR_W-1:0];
              mem_req_o.wdata = mem_rdata_i;
              idx_d           = idx_p1;
              if (idx_p2 < count_q) begin
                addr_d  = idx_p2[ble_pkg::ADDR_W-1:0];
                state_d = S_READ;
              end else begin
                count_d = cnt_m1;
              end
            end
          end
          ble_pkg::CMD_INSERT: begin
            // move entry down by one to open the middle slot
            mem_req_o.we    = 1'b1;
            mem_req_o.waddr = idx_q[ble_pkg::ADDR_W-1:0];
            mem_req_o.wdata = mem_rdata_i;
            idx_d           = idx_m1;
            if (idx_m1 > half) begin
              addr_d  = idx_m2[ble_pkg::ADDR_W-1:0];
              state_d = S_READ;
            end else begin
              state_d = S_WRVAL;
            end
          end
          ble_pkg::CMD_SEARCH: begin
            if (hit) begin
              res_hit_d = 1'b1;
            end
            idx_d = idx_p1;
            if (idx_p1 < count_q) begin
              addr_d  = idx_p1[ble_pkg::ADDR_W-1:0];
              state_d = S_READ;
            end
          end
          ble_pkg::CMD_REVERSE: begin
            if (!ph_q) begin
              tmp_d   = mem_rdata_i;
              ph_d    = 1'b1;
              addr_d  = jdx_q[ble_pkg::ADDR_W-1:0];
              state_d = S_READ;
            end else begin
              mem_req_o.we    = 1'b1;
              mem_req_o.waddr = idx_q[ble_pkg::ADDR_W-1:0];
              mem_req_o.wdata = mem_rdata_i;
              ph_d            = 1'b0;
              state_d         = S_WRJ;
            end
          end
          default: begin
            state_d = S_DONE;
          end
        endcase
      end

      S_WRJ: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = jdx_q[ble_pkg::ADDR_W-1:0];
        mem_req_o.wdata = tmp_q;
        idx_d           = idx_p1;
        jdx_d           = jdx_m1;
        if (idx_p1 < jdx_m1) begin
          addr_d  = idx_p1[ble_pkg::ADDR_W-1:0];
          state_d = S_READ;
        end else begin
          state_d = S_DONE;
        end
      end

      S_WRVAL: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = half[ble_pkg::ADDR_W-1:0];
        mem_req_o.wdata = val_q;
        count_d         = count_q + ble_pkg::CNT_W'(1);
        state_d         = S_DONE;
      end

      S_DONE: begin
        if (res_take_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      ph_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      ph_q    <= ph_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    val_q     <= val_d;
    tmp_q     <= tmp_d;
    idx_q     <= idx_d;
    jdx_q     <= jdx_d;
    addr_q    <= addr_d;
    res_val_q <= res_val_d;
    res_hit_q <= res_hit_d;
    res_st_q  <= res_st_d;
  end

  assign in_ready_o     = (state_q == S_IDLE);
  assign res_valid_o    = (state_q == S_DONE);
  assign res_o.value    = res_val_q;
  assign res_o.found    = res_hit_q;
  assign res_o.length   = count_q;
  assign res_o.status   = res_st_q;

endmodule

FILE: rtl/bounded_list_engine_top.sv
// ----------------------------------------------------------------------------
// bounded_list_engine_top: bounded ordered list of signed 32-bit values
// commands append, pop, remove at index, insert middle, search, clear,
// reverse and length; one result transfer per command transfer
// ----------------------------------------------------------------------------
//
// channel   dir  tdata (low bit up)                          tuser
// s_axis    in   value[31:0] position[39:32] zero[47:40]     command[2:0]
// m_axis    out  result_value[31:0] found[32] length[41:33]  -
//                status[44:42] zero[47:45]
//
// append, clear, length and all error cases finish without a store read;
// pop reads the last entry; search, remove, insert middle and reverse walk
// the store (reverse swaps pairs from both ends towards the middle)
// the store's registered read data sets the step: a read state, then a state
// that uses the word, per element moved or compared; a swap adds a second
// read and the far-end write
// reset clears the sequencer, the element count and the output stage; the
// store itself needs no clearing since only entries below the count are read
// a finished result waits in the output register, so a new command transfer
// is taken while the previous result is still stalled on m_axis
// ----------------------------------------------------------------------------
module bounded_list_engine_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [47:0] s_axis_tdata_i,   // value, position
  input  logic [2:0]  s_axis_tuser_i,   // command
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o    // result_value, found, length, status
);

  ble_pkg::in_t                in_item;
  ble_pkg::res_t               res;
  ble_pkg::mem_req_t           mem_req;
  logic [ble_pkg::DATA_W-1:0]  mem_rdata;
  logic                        res_valid;
  logic                        res_take;

  ble_pkg::res_t               out_q;
  logic                        out_valid_q;

  // unpack the command transfer
  assign in_item.cmd      = ble_pkg::cmd_e'(s_axis_tuser_i);
  assign in_item.value    = s_axis_tdata_i[31:0];
  assign in_item.position = s_axis_tdata_i[39:32];

  ble_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_i        (in_item),
    .res_valid_o (res_valid),
    .res_take_i  (res_take),
    .res_o       (res),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata)
  );

  ble_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  // output register: loads when empty or being drained this cycle
  assign res_take = res_valid && (!out_valid_q || m_axis_tready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_take) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {3'b000, out_q.status, out_q.length, out_q.found, out_q.value};

`ifndef NO_ASSERTIONS
  // a command transfer always starts a walk or a result, never a second take
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("sequencer ready right after a command transfer");

  // any error status carries the error value
  a_err_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_q.status != ble_pkg::ST_OK) |-> (out_q.value == ble_pkg::ERR_VALUE))
    else $error("error result without error value");

  // a search hit only comes with an ok status
  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.found |-> (out_q.status == ble_pkg::ST_OK))
    else $error("found flag with error status");

  // the count never runs past the store size
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> (res.length <= ble_pkg::CNT_W'(ble_pkg::CAPACITY)))
    else $error("element count beyond capacity");
`endif

endmodule
